// ----- hdl/rpq_pkg.sv -----
package rpq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LIMIT_W     = 5;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Field widths
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int UNITS_W  = 8;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int WAIT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_SEIZE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CANCEL  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RETURNED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_HANDED    = 3'd4;
    localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd5;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_UNITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMITED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT   = 2'd2;

    // Chain operations
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // One waiter
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Ripple signals handed from cell to cell
    typedef struct packed {
        logic keep;   // this and all earlier cells stay put on insert
        logic hit;    // a cancel match at or before this cell
    } t_link;

endpackage

// ----- hdl/resource_pool_with_priority_wait_queue.sv -----
// Flow: a transaction accepted in the idle state runs in the exec state; its result is
// registered once the output slot is free, and a cancel stays in the cancel state
// while further waiters match. No new transaction is accepted until the result of
// the last one is loaded; a cancel removes one waiter per chain shift.
// Reset (synchronous, active low): free units 1, no waiters, queue limit off
// with limit 16, no result pending.
module resource_pool_with_priority_wait_queue
    import rpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ID_W-1:0]      i_requester_id,
    input  logic [PRIO_W-1:0]    i_priority_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [ID_W-1:0]      o_handed_id,
    output logic [UNITS_W-1:0]   o_free_units,
    output logic [WAIT_W-1:0]    o_waiting_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_CANCEL = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [UNITS_W-1:0] r_free, n_free;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_q_limited;
    logic [LIMIT_W-1:0] r_q_limit;
    logic [ACT_W-1:0]   r_act;
    t_entry             r_key;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [ID_W-1:0]    r_out_handed;
    logic [UNITS_W-1:0] r_out_free;
    logic [WAIT_W-1:0]  r_out_wait;

    logic               w_out_load;
    logic [STAT_W-1:0]  w_status;
    logic [ID_W-1:0]    w_handed;
    logic [1:0]         w_op;
    logic               w_slot;
    logic               w_full;
    logic [ID_W-1:0]    w_head_id;
    logic               w_any_match;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_full     = (r_count >= CNT_W'(QUEUE_DEPTH)) ||
                        (r_q_limited && (CMP_W'(r_count) >= CMP_W'(r_q_limit)));

    rpq_chain u_chain (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_count     (r_count),
        .i_key       (r_key),
        .o_head_id   (w_head_id),
        .o_any_match (w_any_match)
    );

    // Sequencer: decide the transaction and drive the chain
    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_count    = r_count;
        w_op       = OP_HOLD;
        w_out_load = 1'b0;
        w_status   = ST_NOT_FOUND;
        w_handed   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_act)
                    ACT_SEIZE: begin
                        if (w_slot) begin
                            w_out_load = 1'b1;
                            n_state    = S_IDLE;
                            if (r_free != '0) begin
                                n_free   = r_free - 1'b1;
                                w_status = ST_GRANTED;
                            end else if (w_full) begin
                                w_status = ST_REJECTED;
                            end else begin
                                w_op     = OP_INSERT;
                                n_count  = r_count + 1'b1;
                                w_status = ST_QUEUED;
                            end
                        end
                    end
                    ACT_RELEASE: begin
                        if (w_slot) begin
                            w_out_load = 1'b1;
                            n_state    = S_IDLE;
                            if (r_count == '0) begin
                                if (r_free != '1) begin
                                    n_free = r_free + 1'b1;
                                end
                                w_status = ST_RETURNED;
                            end else begin
                                w_op     = OP_POP;
                                n_count  = r_count - 1'b1;
                                w_handed = w_head_id;
                                w_status = ST_HANDED;
                            end
                        end
                    end
                    ACT_CANCEL: begin
                        if (w_any_match) begin
                            w_op    = OP_REMOVE;
                            n_count = r_count - 1'b1;
                            n_state = S_CANCEL;
                        end else if (w_slot) begin
                            w_out_load = 1'b1;
                            w_status   = ST_NOT_FOUND;
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        if (w_slot) begin
                            w_out_load = 1'b1;
                            w_status   = ST_NOT_FOUND;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_CANCEL: begin
                // one matching waiter leaves per pass
                if (w_any_match) begin
                    w_op    = OP_REMOVE;
                    n_count = r_count - 1'b1;
                end else if (w_slot) begin
                    w_out_load = 1'b1;
                    w_status   = ST_CANCELLED;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // writing total units reloads the pool
        if (i_cfg_we && (i_cfg_index == REG_TOTAL_UNITS)) begin
            n_free = i_cfg_data[UNITS_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= UNITS_W'(1);
            r_count     <= '0;
            r_q_limited <= 1'b0;
            r_q_limit   <= LIMIT_W'(16);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_count <= n_count;
            if (i_cfg_we && (i_cfg_index == REG_QUEUE_LIMITED)) begin
                r_q_limited <= i_cfg_data[0];
            end
            if (i_cfg_we && (i_cfg_index == REG_QUEUE_LIMIT)) begin
                r_q_limit <= i_cfg_data[LIMIT_W-1:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured transaction and result payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_act      <= i_action;
            r_key.id   <= i_requester_id;
            r_key.prio <= i_priority_req;
        end
        if (w_out_load) begin
            r_out_status <= w_status;
            r_out_handed <= w_handed;
            r_out_free   <= n_free;
            r_out_wait   <= WAIT_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_handed_id     = r_out_handed;
    assign o_free_units    = r_out_free;
    assign o_waiting_count = r_out_wait;

endmodule

// ----- hdl/rpq_cell.sv -----
module rpq_cell
    import rpq_pkg::*;
(
    input  logic         i_clk,
    input  logic [1:0]   i_op,
    input  logic         i_occ,
    input  t_entry       i_key,
    input  t_link        i_link,
    input  t_entry       i_prev,
    input  t_entry       i_next,
    output t_entry       o_entry,
    output t_link        o_link
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_keep;
    logic   w_match;

    // Local compare against the broadcast key
    assign w_keep  = i_occ && (r_entry.prio >= i_key.prio);
    assign w_match = i_occ && (r_entry.id == i_key.id);

    assign o_link.keep = w_keep;
    assign o_link.hit  = i_link.hit | w_match;
    assign o_entry     = r_entry;

    // Next entry: hold, take key, or shift from a neighbor
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            OP_INSERT: begin
                if (w_keep) begin
                    n_entry = r_entry;
                end else if (i_link.keep) begin
                    n_entry = i_key;
                end else begin
                    n_entry = i_prev;
                end
            end
            OP_POP: begin
                n_entry = i_next;
            end
            OP_REMOVE: begin
                if (o_link.hit) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hdl/rpq_chain.sv -----
module rpq_chain
    import rpq_pkg::*;
(
    input  logic             i_clk,
    input  logic [1:0]       i_op,
    input  logic [CNT_W-1:0] i_count,
    input  t_entry           i_key,
    output logic [ID_W-1:0]  o_head_id,
    output logic             o_any_match
);

    t_entry w_entry [QUEUE_DEPTH];
    t_link  w_link  [QUEUE_DEPTH+1];
    logic   w_occ   [QUEUE_DEPTH];

    // Head of the chain: insert lands in cell 0 unless it keeps
    assign w_link[0].keep = 1'b1;
    assign w_link[0].hit  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;

            assign w_occ[g] = (i_count > CNT_W'(g));

            if (g == 0) begin : g_first
                assign w_prev = i_key;
            end else begin : g_mid
                assign w_prev = w_entry[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_next = i_key;
            end else begin : g_inner
                assign w_next = w_entry[g+1];
            end

            rpq_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (i_op),
                .i_occ   (w_occ[g]),
                .i_key   (i_key),
                .i_link  (w_link[g]),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_entry (w_entry[g]),
                .o_link  (w_link[g+1])
            );
        end
    endgenerate

    assign o_head_id   = w_entry[0].id;
    assign o_any_match = w_link[QUEUE_DEPTH].hit;

endmodule

// ----- hdl/rpq_checker.sv -----
module rpq_checker
    import rpq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [STAT_W-1:0]    o_status,
    input logic [ID_W-1:0]      o_handed_id,
    input logic [UNITS_W-1:0]   o_free_units,
    input logic [WAIT_W-1:0]    o_waiting_count
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
            $stable(o_handed_id) && $stable(o_free_units) && $stable(o_waiting_count))
        else $error("result changed while stalled");

    // Only a hand-on names a requester
    a_handed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_HANDED) |-> o_handed_id == '0)
        else $error("handed id set without hand-on");

    // Waiter count never exceeds the queue
    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_waiting_count <= WAIT_W'(QUEUE_DEPTH))
        else $error("waiting count beyond depth");

    // A requester only queues when the pool is empty
    a_queue_empty_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_QUEUED) |-> o_free_units == '0)
        else $error("queued with free units");

    // A requester is only turned away when the pool is empty
    a_reject_empty_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_REJECTED) |-> o_free_units == '0)
        else $error("rejected with free units");

endmodule

bind resource_pool_with_priority_wait_queue rpq_checker u_rpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_handed_id     (o_handed_id),
    .o_free_units    (o_free_units),
    .o_waiting_count (o_waiting_count)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rpq_pkg::*;

    // Codes the package does not name
    localparam logic [ACT_W-1:0]     ACT_NOOP    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    localparam int N_DIR          = 25;
    localparam int N_PHASES       = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int EXP_DEPTH      = 2048;

    // One result transaction
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    handed;
        logic [UNITS_W-1:0] free_units;
        logic [WAIT_W-1:0]  waiting;
    } pool_result_t;

    // One directed step: a transaction or a register write
    typedef struct packed {
        logic                 is_cfg;
        logic [ACT_W-1:0]     act;
        logic [ID_W-1:0]      id;
        logic [PRIO_W-1:0]    prio;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_DAT_W-1:0] cfg_val;
        logic                 typed;
        pool_result_t         want;
    } dir_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ACT_W-1:0]     i_action;
    logic [ID_W-1:0]      i_requester_id;
    logic [PRIO_W-1:0]    i_priority_req;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [STAT_W-1:0]    o_status;
    logic [ID_W-1:0]      o_handed_id;
    logic [UNITS_W-1:0]   o_free_units;
    logic [WAIT_W-1:0]    o_waiting_count;

    resource_pool_with_priority_wait_queue DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_requester_id  (i_requester_id),
        .i_priority_req  (i_priority_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_handed_id     (o_handed_id),
        .o_free_units    (o_free_units),
        .o_waiting_count (o_waiting_count)
    );

    // Pool state as the testbench sees it
    logic               cfg_lim_on;
    logic [4:0]         cfg_limit;
    logic [UNITS_W-1:0] units_free;
    logic [ID_W-1:0]    waiter_id   [QUEUE_DEPTH];
    logic [PRIO_W-1:0]  waiter_prio [QUEUE_DEPTH];
    int                 waiter_cnt;

    // Expected results, written by the sender and read by the checker
    pool_result_t exp_fifo [EXP_DEPTH];
    int           exp_wr;
    int           exp_rd;
    int           fail_count;
    int           burst_left;
    int           idle_cycles;
    bit           run_done;
    int           rx_cyc;
    int           rx_mode;

    // Directed steps; typed expectations only where they are obvious
    //   is_cfg, act, id, prio, cfg_idx, cfg_val, typed, {status, handed, free, waiting}
    dir_row_t dir_rows [N_DIR] = '{
        '{1'b0, ACT_SEIZE,   16'h0001, 8'h10, 2'd0, 8'd0, 1'b1, '{ST_GRANTED, 16'h0, 8'd0, 5'd0}},
        '{1'b0, ACT_SEIZE,   16'h0000, 8'h00, 2'd0, 8'd0, 1'b1, '{ST_QUEUED, 16'h0, 8'd0, 5'd1}},
        '{1'b0, ACT_SEIZE,   16'hFFFF, 8'hFF, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'h1234, 8'hFF, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'h0005, 8'h80, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'h0005, 8'h01, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_CANCEL,  16'h0005, 8'h00, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_CANCEL,  16'hBEEF, 8'h00, 2'd0, 8'd0, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'd0, 5'd3}},
        '{1'b0, ACT_NOOP,    16'hAAAA, 8'h55, 2'd0, 8'd0, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'd0, 5'd3}},
        '{1'b0, ACT_RELEASE, 16'h0000, 8'h00, 2'd0, 8'd0, 1'b1, '{ST_HANDED, 16'hFFFF, 8'd0, 5'd2}},
        '{1'b1, ACT_SEIZE,   16'h0000, 8'h00, REG_TOTAL_UNITS, 8'd3, 1'b0, '0},
        '{1'b0, ACT_RELEASE, 16'h0000, 8'h00, 2'd0, 8'd0, 1'b0, '0},
        '{1'b1, ACT_SEIZE,   16'h0000, 8'h00, REG_QUEUE_LIMITED, 8'd1, 1'b0, '0},
        '{1'b1, ACT_SEIZE,   16'h0000, 8'h00, REG_QUEUE_LIMIT, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'h00FF, 8'h00, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'hFF00, 8'hF0, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'h5A5A, 8'h0F, 2'd0, 8'd0, 1'b0, '0},
        '{1'b0, ACT_SEIZE,   16'h5555, 8'h7F, 2'd0, 8'd0, 1'b1, '{ST_REJECTED, 16'h0, 8'd0, 5'd1}},
        '{1'b0, ACT_RELEASE, 16'h0000, 8'h00, 2'd0, 8'd0, 1'b1, '{ST_HANDED, 16'h0000, 8'd0, 5'd0}},
        '{1'b1, ACT_SEIZE,   16'h0000, 8'h00, REG_TOTAL_UNITS, 8'd255, 1'b0, '0},
        '{1'b1, ACT_SEIZE,   16'h0000, 8'h00, REG_QUEUE_LIMIT, 8'd16, 1'b0, '0},
        '{1'b1, ACT_SEIZE,   16'h0000, 8'h00, REG_QUEUE_LIMITED, 8'd0, 1'b0, '0},
        '{1'b0, ACT_RELEASE, 16'h0000, 8'h00, 2'd0, 8'd0, 1'b1, '{ST_RETURNED, 16'h0, 8'd255, 5'd0}},
        '{1'b0, ACT_SEIZE,   16'hAAAA, 8'h55, 2'd0, 8'd0, 1'b1, '{ST_GRANTED, 16'h0, 8'd254, 5'd0}},
        '{1'b0, ACT_CANCEL,  16'hFFFF, 8'h00, 2'd0, 8'd0, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'd254, 5'd0}}
    };

    // Register write into the predicted pool
    function automatic void pool_configure(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_TOTAL_UNITS:   units_free = val;
            REG_QUEUE_LIMITED: cfg_lim_on = val[0];
            REG_QUEUE_LIMIT:   cfg_limit  = val[4:0];
            default: ;
        endcase
    endfunction

    // Predict the result of one transaction and advance the pool
    function automatic pool_result_t pool_predict(logic [ACT_W-1:0] act,
                                                  logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] prio);
        pool_result_t res;
        int           pos;
        int           k;
        int           wr;
        bit           hit;
        res = '0;
        case (act)
            ACT_SEIZE: begin
                if (units_free != 0) begin
                    units_free = units_free - 1'b1;
                    res.status = ST_GRANTED;
                end else if (waiter_cnt >= QUEUE_DEPTH ||
                             (cfg_lim_on && waiter_cnt >= int'(cfg_limit))) begin
                    res.status = ST_REJECTED;
                end else begin
                    // behind every waiter of equal or higher priority
                    pos = 0;
                    while (pos < waiter_cnt && waiter_prio[pos] >= prio)
                        pos++;
                    for (k = waiter_cnt; k > pos; k--) begin
                        waiter_id[k]   = waiter_id[k-1];
                        waiter_prio[k] = waiter_prio[k-1];
                    end
                    waiter_id[pos]   = id;
                    waiter_prio[pos] = prio;
                    waiter_cnt++;
                    res.status = ST_QUEUED;
                end
            end
            ACT_RELEASE: begin
                if (waiter_cnt == 0) begin
                    if (units_free != 8'd255)
                        units_free = units_free + 1'b1;
                    res.status = ST_RETURNED;
                end else begin
                    res.handed = waiter_id[0];
                    for (k = 1; k < waiter_cnt; k++) begin
                        waiter_id[k-1]   = waiter_id[k];
                        waiter_prio[k-1] = waiter_prio[k];
                    end
                    waiter_cnt--;
                    res.status = ST_HANDED;
                end
            end
            ACT_CANCEL: begin
                // drop every waiter with this id, keep the rest in order
                wr  = 0;
                hit = 1'b0;
                for (k = 0; k < waiter_cnt; k++) begin
                    if (waiter_id[k] == id) begin
                        hit = 1'b1;
                    end else begin
                        waiter_id[wr]   = waiter_id[k];
                        waiter_prio[wr] = waiter_prio[k];
                        wr++;
                    end
                end
                waiter_cnt = wr;
                res.status = hit ? ST_CANCELLED : ST_NOT_FOUND;
            end
            default: res.status = ST_NOT_FOUND;
        endcase
        res.free_units = units_free;
        res.waiting    = WAIT_W'(waiter_cnt);
        return res;
    endfunction

    // Offer one transaction, record its expected result once accepted
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input pool_result_t want);
        pool_result_t res;
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_requester_id <= id;
        i_priority_req <= prio;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        res = pool_predict(act, id, prio);
        exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : res;
        exp_wr++;
        @(negedge i_clk);
        // sender bursts and gaps
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Let every outstanding result come back before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        pool_configure(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stall pattern, switching mode now and then
    initial begin
        i_out_ready = 1'b0;
        rx_cyc      = 0;
        rx_mode     = 0;
        forever begin
            @(negedge i_clk);
            rx_cyc++;
            if (rx_cyc % 150 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 9) < 6);
                2:       i_out_ready <= ((rx_cyc % 7) < 4);
                default: i_out_ready <= ((rx_cyc % 24) >= 16);
            endcase
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        pool_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: result with nothing expected: status %0d", $time, o_status);
                fail_count++;
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_handed_id !== want.handed) begin
                    $display("%0t: handed_id expected %h, actual %h",
                             $time, want.handed, o_handed_id);
                    fail_count++;
                end
                if (o_free_units !== want.free_units) begin
                    $display("%0t: free_units expected %0d, actual %0d",
                             $time, want.free_units, o_free_units);
                    fail_count++;
                end
                if (o_waiting_count !== want.waiting) begin
                    $display("%0t: waiting_count expected %0d, actual %0d",
                             $time, want.waiting, o_waiting_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || run_done || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** resource_pool_with_priority_wait_queue: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int                p;
        int                n;
        int                r;
        int                seize_pct;
        logic [ACT_W-1:0]  act;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [7:0]        tot;
        logic              lim_on;
        logic [4:0]        lim;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_action       = '0;
        i_requester_id = '0;
        i_priority_req = '0;
        run_done       = 1'b0;
        burst_left     = 4;

        // pool after reset
        cfg_lim_on = 1'b0;
        cfg_limit  = 5'd16;
        units_free = 8'd1;
        waiter_cnt = 0;
        for (n = 0; n < QUEUE_DEPTH; n++) begin
            waiter_id[n]   = '0;
            waiter_prio[n] = '0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part
        for (n = 0; n < N_DIR; n++) begin
            if (dir_rows[n].is_cfg) begin
                wait_idle();
                cfg_write(dir_rows[n].cfg_idx, dir_rows[n].cfg_val);
            end else begin
                send_item(dir_rows[n].act, dir_rows[n].id, dir_rows[n].prio,
                          dir_rows[n].typed, dir_rows[n].want);
            end
        end

        // Random part, one register setting per phase
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin tot = 8'd1;   lim_on = 1'b0; lim = 5'd16; seize_pct = 80; end
                1: begin tot = 8'd255; lim_on = 1'b1; lim = 5'd16; seize_pct = 45; end
                2: begin tot = 8'd2;   lim_on = 1'b1; lim = 5'd0;  seize_pct = 60; end
                3: begin tot = 8'd1;   lim_on = 1'b1; lim = 5'd1;  seize_pct = 70; end
                default: begin
                    tot       = 8'($urandom_range(1, 6));
                    lim_on    = 1'($urandom_range(0, 1));
                    lim       = 5'($urandom_range(0, 16));
                    seize_pct = $urandom_range(30, 80);
                end
            endcase
            wait_idle();
            cfg_write(REG_TOTAL_UNITS, tot);
            cfg_write(REG_QUEUE_LIMITED, {7'd0, lim_on});
            cfg_write(REG_QUEUE_LIMIT, {3'd0, lim});
            // index past the register list must be ignored
            cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)));

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    act = ACT_NOOP;
                else if (r < 3 + seize_pct)
                    act = ACT_SEIZE;
                else if (r < 15 + seize_pct)
                    act = ACT_CANCEL;
                else
                    act = ACT_RELEASE;

                // ids mostly from a small set or from the queue, so cancels hit
                if (waiter_cnt > 0 && $urandom_range(0, 1) == 1)
                    id = waiter_id[$urandom_range(0, waiter_cnt - 1)];
                else if ($urandom_range(0, 1) == 1)
                    id = ID_W'($urandom_range(0, 7));
                else
                    id = ID_W'($urandom_range(0, 65535));

                // many equal priorities to exercise first-come ordering
                case ($urandom_range(0, 3))
                    0:       prio = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                    1:       prio = 8'($urandom_range(0, 3) * 85);
                    default: prio = 8'($urandom_range(0, 255));
                endcase

                send_item(act, id, prio, 1'b0, '0);
            end
        end

        // Drain and report
        wait_idle();
        run_done = 1'b1;
        if (fail_count == 0 && exp_wr == exp_rd) begin
            $display("** resource_pool_with_priority_wait_queue: PASSED **");
        end else begin
            $display("** resource_pool_with_priority_wait_queue: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rpq_pkg.sv
hdl/rpq_cell.sv
hdl/rpq_chain.sv
hdl/resource_pool_with_priority_wait_queue.sv
hdl/rpq_checker.sv
tb/testbench.sv
